FILE: src/cgb_pkg.sv
// shared codes and types for the csr graph builder
package cgb_pkg;

  localparam int ID_W = 10;

  typedef logic [ID_W-1:0] vid_t;
  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_BUILD = 2'd1;
  localparam op_t OP_ROW   = 2'd2;
  localparam op_t OP_SLOT  = 2'd3;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  localparam logic [ID_W-1:0] DEG_MAX = '1;

endpackage

FILE: src/csr_graph_builder_top.sv
// csr graph builder: edge store, counting-sort build engine and table reads
// load, row read and slot read end with done, also when rejected; done for one cycle
// build: two sort passes, dedup, offsets and reverse fill, then done
// after rst a clearing pass over all VERTEX_LIMIT entries wipes the vertex-seen map, busy stays high
// results cannot be stalled; the next item is taken in the cycle done is shown
module csr_graph_builder_top #(
  parameter int VERTEX_LIMIT = 1024,
  parameter int EDGE_LIMIT   = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cgb_pkg::op_t         operation,
  input  logic [9:0]           src_vertex,
  input  logic [9:0]           dst_vertex,
  input  logic [10:0]          vertex_index,
  input  logic [11:0]          slot_index,
  output logic                 done,
  output cgb_pkg::status_t     status,
  output logic [12:0]          out_offset,
  output logic [9:0]           out_degree,
  output logic [12:0]          in_offset,
  output logic [9:0]           in_degree,
  output logic [9:0]           out_neighbor,
  output logic [9:0]           in_neighbor,
  output logic [12:0]          edge_total,
  output logic [10:0]          vertex_total,
  output logic [9:0]           largest_vertex_id,
  output logic [9:0]           max_out_degree
);

  localparam int CW  = $clog2(EDGE_LIMIT + 1);
  localparam int EAW = (EDGE_LIMIT > 1) ? $clog2(EDGE_LIMIT) : 1;
  localparam int OAW = $clog2(VERTEX_LIMIT + 1);
  localparam int SW  = $clog2(VERTEX_LIMIT);
  localparam logic [CW-1:0]  EL_C   = CW'(EDGE_LIMIT);
  localparam logic [OAW-1:0] VL_C   = OAW'(VERTEX_LIMIT);
  localparam logic [OAW-1:0] VLM1_C = OAW'(VERTEX_LIMIT - 1);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_LD0     = 5'd2;
  localparam logic [4:0] S_LD1     = 5'd3;
  localparam logic [4:0] S_LD2     = 5'd4;
  localparam logic [4:0] S_RR0     = 5'd5;
  localparam logic [4:0] S_RR1     = 5'd6;
  localparam logic [4:0] S_SR0     = 5'd7;
  localparam logic [4:0] S_SR1     = 5'd8;
  localparam logic [4:0] B_CLR     = 5'd9;
  localparam logic [4:0] B_CNT_RD  = 5'd10;
  localparam logic [4:0] B_CNT_KEY = 5'd11;
  localparam logic [4:0] B_CNT_WR  = 5'd12;
  localparam logic [4:0] B_PFX_RD  = 5'd13;
  localparam logic [4:0] B_PFX_WR  = 5'd14;
  localparam logic [4:0] B_SCT_RD  = 5'd15;
  localparam logic [4:0] B_SCT_KEY = 5'd16;
  localparam logic [4:0] B_SCT_WR  = 5'd17;
  localparam logic [4:0] B_DD_RD   = 5'd18;
  localparam logic [4:0] B_DD_CHK  = 5'd19;
  localparam logic [4:0] B_DD_WR   = 5'd20;
  localparam logic [4:0] B_OFS_RD  = 5'd21;
  localparam logic [4:0] B_OFS_WR  = 5'd22;
  localparam logic [4:0] B_REV_RD  = 5'd23;
  localparam logic [4:0] B_REV_KEY = 5'd24;
  localparam logic [4:0] B_REV_WR  = 5'd25;

  function automatic logic [9:0] sat_deg(input logic [CW-1:0] d);
    if (32'(d) > 32'(cgb_pkg::DEG_MAX)) begin
      return cgb_pkg::DEG_MAX;
    end
    return 10'(d);
  endfunction

  logic [4:0]         state;
  logic [OAW-1:0]     j;
  logic [CW-1:0]      i;
  logic [CW-1:0]      k;
  logic               pass;
  logic [CW-1:0]      loaded;
  logic [OAW-1:0]     distinct;
  cgb_pkg::vid_t      top;
  logic [CW-1:0]      unique_cnt;
  logic [9:0]         peak;
  logic               built;
  cgb_pkg::vid_t      src_r;
  cgb_pkg::vid_t      dst_r;
  logic [10:0]        vix_r;
  logic [11:0]        six_r;
  logic [OAW-1:0]     kaddr;
  logic [OAW-1:0]     kaddr2;
  logic [19:0]        ereg;
  logic [19:0]        prev;
  logic               have_prev;
  logic [CW-1:0]      acc;
  logic [CW-1:0]      facc;
  logic [CW-1:0]      racc;
  logic [CW-1:0]      maxo;

  // memories
  logic [19:0]    es_mem [EDGE_LIMIT];
  logic [19:0]    wa_mem [EDGE_LIMIT];
  logic [19:0]    wb_mem [EDGE_LIMIT];
  logic           seen_mem [VERTEX_LIMIT];
  logic [CW-1:0]  cnt_mem [VERTEX_LIMIT + 1];
  logic [CW-1:0]  f_mem [VERTEX_LIMIT + 1];
  logic [CW-1:0]  r_mem [VERTEX_LIMIT + 1];
  logic [9:0]     fadj_mem [EDGE_LIMIT];
  logic [9:0]     radj_mem [EDGE_LIMIT];

  logic           es_we, wa_we, wb_we, seen_we, cnt_we, f_we, r_we, fadj_we, radj_we;
  logic [EAW-1:0] es_wa, es_ra, wa_wa, wa_ra, wb_wa, wb_ra, adj_wa, adj_ra, radj_wa;
  logic [19:0]    es_wd, wa_wd, wb_wd;
  logic [SW-1:0]  seen_wa, seen_ra, seen_rb;
  logic           seen_wd, seen_rda, seen_rdb;
  logic [OAW-1:0] cnt_wa, cnt_ra, f_wa, f_ra, f_rb, r_wa, r_ra, r_rb;
  logic [CW-1:0]  cnt_wd, f_wd, r_wd;
  logic [9:0]     fadj_wd, radj_wd;
  logic [19:0]    es_rd, wa_rd, wb_rd;
  logic [CW-1:0]  cnt_rd, f_rda, f_rdb, r_rda, r_rdb;
  logic [9:0]     fadj_rd, radj_rd;

  logic [19:0]    src_rd;
  logic [9:0]     sort_key;
  logic           dd_keep;
  logic           load_bad;
  logic           load_full;

  assign src_rd   = pass ? wa_rd : es_rd;
  assign sort_key = pass ? src_rd[9:0] : src_rd[19:10];
  assign dd_keep  = !(have_prev && (wb_rd == prev)) && (wb_rd[9:0] != wb_rd[19:10]);
  assign load_bad = (32'(src_r) >= 32'(VERTEX_LIMIT)) || (32'(dst_r) >= 32'(VERTEX_LIMIT));
  assign load_full = (loaded == EL_C);

  always_ff @(posedge clk) begin
    if (es_we) begin
      es_mem[es_wa] <= es_wd;
    end
    es_rd <= es_mem[es_ra];
  end

  always_ff @(posedge clk) begin
    if (wa_we) begin
      wa_mem[wa_wa] <= wa_wd;
    end
    wa_rd <= wa_mem[wa_ra];
  end

  always_ff @(posedge clk) begin
    if (wb_we) begin
      wb_mem[wb_wa] <= wb_wd;
    end
    wb_rd <= wb_mem[wb_ra];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_rda <= seen_mem[seen_ra];
    seen_rdb <= seen_mem[seen_rb];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      f_mem[f_wa] <= f_wd;
    end
    f_rda <= f_mem[f_ra];
    f_rdb <= f_mem[f_rb];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[r_wa] <= r_wd;
    end
    r_rda <= r_mem[r_ra];
    r_rdb <= r_mem[r_rb];
  end

  always_ff @(posedge clk) begin
    if (fadj_we) begin
      fadj_mem[adj_wa] <= fadj_wd;
    end
    fadj_rd <= fadj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (radj_we) begin
      radj_mem[radj_wa] <= radj_wd;
    end
    radj_rd <= radj_mem[adj_ra];
  end

  // memory port control
  always_comb begin
    es_we = 1'b0; es_wa = '0; es_wd = '0; es_ra = '0;
    wa_we = 1'b0; wa_wa = '0; wa_wd = '0; wa_ra = '0;
    wb_we = 1'b0; wb_wa = '0; wb_wd = '0; wb_ra = '0;
    seen_we = 1'b0; seen_wa = '0; seen_wd = 1'b0; seen_ra = '0; seen_rb = '0;
    cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0; f_rb = '0;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0; r_rb = '0;
    fadj_we = 1'b0; adj_wa = '0; fadj_wd = '0; adj_ra = '0;
    radj_we = 1'b0; radj_wa = '0; radj_wd = '0;
    unique case (state)
      S_INIT: begin
        seen_we = 1'b1;
        seen_wa = SW'(j);
      end
      S_LD0: begin
        es_we   = !load_bad && !load_full;
        es_wa   = loaded[EAW-1:0];
        es_wd   = {dst_r, src_r};
        seen_ra = SW'(src_r);
        seen_rb = SW'(dst_r);
      end
      S_LD1: begin
        seen_we = 1'b1;
        seen_wa = SW'(src_r);
        seen_wd = 1'b1;
      end
      S_LD2: begin
        seen_we = 1'b1;
        seen_wa = SW'(dst_r);
        seen_wd = 1'b1;
      end
      S_RR0: begin
        f_ra = OAW'(vix_r);
        f_rb = (32'(vix_r) == 32'(VERTEX_LIMIT)) ? OAW'(vix_r) : OAW'(vix_r) + 1'b1;
        r_ra = f_ra;
        r_rb = f_rb;
      end
      S_SR0: begin
        adj_ra = EAW'(six_r);
      end
      B_CLR: begin
        cnt_we = 1'b1; cnt_wa = j;
        f_we   = 1'b1; f_wa   = j;
        r_we   = 1'b1; r_wa   = j;
      end
      B_CNT_RD, B_SCT_RD: begin
        es_ra = i[EAW-1:0];
        wa_ra = i[EAW-1:0];
      end
      B_CNT_KEY: begin
        cnt_ra = OAW'(sort_key) + 1'b1;
      end
      B_CNT_WR: begin
        cnt_we = 1'b1; cnt_wa = kaddr; cnt_wd = cnt_rd + 1'b1;
      end
      B_PFX_RD: begin
        cnt_ra = j;
      end
      B_PFX_WR: begin
        cnt_we = 1'b1; cnt_wa = j; cnt_wd = acc + cnt_rd;
      end
      B_SCT_KEY: begin
        cnt_ra = OAW'(sort_key);
      end
      B_SCT_WR: begin
        cnt_we = 1'b1; cnt_wa = kaddr; cnt_wd = cnt_rd + 1'b1;
        wa_we  = !pass; wa_wa = cnt_rd[EAW-1:0]; wa_wd = ereg;
        wb_we  = pass;  wb_wa = cnt_rd[EAW-1:0]; wb_wd = ereg;
      end
      B_DD_RD: begin
        wb_ra = i[EAW-1:0];
      end
      B_DD_CHK: begin
        wa_we   = dd_keep; wa_wa = k[EAW-1:0]; wa_wd = wb_rd;
        fadj_we = dd_keep; adj_wa = k[EAW-1:0]; fadj_wd = wb_rd[19:10];
        f_ra    = OAW'(wb_rd[9:0]) + 1'b1;
        r_ra    = OAW'(wb_rd[19:10]) + 1'b1;
      end
      B_DD_WR: begin
        f_we = 1'b1; f_wa = kaddr;  f_wd = f_rda + 1'b1;
        r_we = 1'b1; r_wa = kaddr2; r_wd = r_rda + 1'b1;
      end
      B_OFS_RD: begin
        f_ra = j;
        r_ra = j;
      end
      B_OFS_WR: begin
        f_we   = 1'b1; f_wa   = j; f_wd   = facc + f_rda;
        r_we   = 1'b1; r_wa   = j; r_wd   = racc + r_rda;
        cnt_we = 1'b1; cnt_wa = j; cnt_wd = racc + r_rda;
      end
      B_REV_RD: begin
        wa_ra = i[EAW-1:0];
      end
      B_REV_KEY: begin
        cnt_ra = OAW'(wa_rd[19:10]);
      end
      B_REV_WR: begin
        cnt_we  = 1'b1; cnt_wa = kaddr; cnt_wd = cnt_rd + 1'b1;
        radj_we = 1'b1; radj_wa = cnt_rd[EAW-1:0]; radj_wd = ereg[9:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      j          <= '0;
      done       <= 1'b0;
      loaded     <= '0;
      distinct   <= '0;
      top        <= '0;
      unique_cnt <= '0;
      peak       <= '0;
      built      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          if (j == VLM1_C) begin
            state <= S_IDLE;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            src_r        <= src_vertex;
            dst_r        <= dst_vertex;
            vix_r        <= vertex_index;
            six_r        <= slot_index;
            status       <= cgb_pkg::ST_OK;
            out_offset   <= '0;
            out_degree   <= '0;
            in_offset    <= '0;
            in_degree    <= '0;
            out_neighbor <= '0;
            in_neighbor  <= '0;
            unique case (operation)
              cgb_pkg::OP_LOAD: state <= S_LD0;
              cgb_pkg::OP_BUILD: begin
                state <= B_CLR;
                j     <= '0;
                pass  <= 1'b0;
              end
              cgb_pkg::OP_ROW: state <= S_RR0;
              cgb_pkg::OP_SLOT: state <= S_SR0;
            endcase
          end
        end
        S_LD0: begin
          priority if (load_bad) begin
            status <= cgb_pkg::ST_BAD;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (load_full) begin
            status <= cgb_pkg::ST_FULL;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_LD1;
          end
        end
        S_LD1: begin
          distinct <= distinct + OAW'(!seen_rda)
                      + OAW'(!seen_rdb && (dst_r != src_r));
          if ((src_r >= dst_r) && (src_r > top)) begin
            top <= src_r;
          end else if ((dst_r > src_r) && (dst_r > top)) begin
            top <= dst_r;
          end
          loaded <= loaded + 1'b1;
          built  <= 1'b0;
          state  <= S_LD2;
        end
        S_LD2: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_RR0: begin
          if (!built || (32'(vix_r) > 32'(VERTEX_LIMIT))) begin
            status <= cgb_pkg::ST_BAD;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_RR1;
          end
        end
        S_RR1: begin
          out_offset <= 13'(f_rda);
          in_offset  <= 13'(r_rda);
          if (32'(vix_r) < 32'(VERTEX_LIMIT)) begin
            out_degree <= sat_deg(f_rdb - f_rda);
            in_degree  <= sat_deg(r_rdb - r_rda);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SR0: begin
          if (!built || (32'(six_r) >= 32'(unique_cnt))
              || (32'(six_r) >= 32'(EDGE_LIMIT))) begin
            status <= cgb_pkg::ST_BAD;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_SR1;
          end
        end
        S_SR1: begin
          out_neighbor <= fadj_rd;
          in_neighbor  <= radj_rd;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        B_CLR: begin
          if (j == VL_C) begin
            i     <= '0;
            state <= B_CNT_RD;
          end else begin
            j <= j + 1'b1;
          end
        end
        B_CNT_RD: begin
          if (i == loaded) begin
            j     <= '0;
            acc   <= '0;
            state <= B_PFX_RD;
          end else begin
            state <= B_CNT_KEY;
          end
        end
        B_CNT_KEY: begin
          kaddr <= OAW'(sort_key) + 1'b1;
          state <= B_CNT_WR;
        end
        B_CNT_WR: begin
          i     <= i + 1'b1;
          state <= B_CNT_RD;
        end
        B_PFX_RD: begin
          state <= B_PFX_WR;
        end
        B_PFX_WR: begin
          acc <= acc + cnt_rd;
          if (j == VL_C) begin
            i     <= '0;
            state <= B_SCT_RD;
          end else begin
            j     <= j + 1'b1;
            state <= B_PFX_RD;
          end
        end
        B_SCT_RD: begin
          priority if (i != loaded) begin
            state <= B_SCT_KEY;
          end else if (!pass) begin
            pass  <= 1'b1;
            j     <= '0;
            state <= B_CLR;
          end else begin
            i         <= '0;
            k         <= '0;
            have_prev <= 1'b0;
            state     <= B_DD_RD;
          end
        end
        B_SCT_KEY: begin
          ereg  <= src_rd;
          kaddr <= OAW'(sort_key);
          state <= B_SCT_WR;
        end
        B_SCT_WR: begin
          i     <= i + 1'b1;
          state <= B_SCT_RD;
        end
        B_DD_RD: begin
          if (i == loaded) begin
            j     <= '0;
            facc  <= '0;
            racc  <= '0;
            maxo  <= '0;
            state <= B_OFS_RD;
          end else begin
            state <= B_DD_CHK;
          end
        end
        B_DD_CHK: begin
          prev      <= wb_rd;
          have_prev <= 1'b1;
          if (dd_keep) begin
            k      <= k + 1'b1;
            kaddr  <= OAW'(wb_rd[9:0]) + 1'b1;
            kaddr2 <= OAW'(wb_rd[19:10]) + 1'b1;
            state  <= B_DD_WR;
          end else begin
            i     <= i + 1'b1;
            state <= B_DD_RD;
          end
        end
        B_DD_WR: begin
          i     <= i + 1'b1;
          state <= B_DD_RD;
        end
        B_OFS_RD: begin
          state <= B_OFS_WR;
        end
        B_OFS_WR: begin
          facc <= facc + f_rda;
          racc <= racc + r_rda;
          if (f_rda > maxo) begin
            maxo <= f_rda;
          end
          if (j == VL_C) begin
            i     <= '0;
            state <= B_REV_RD;
          end else begin
            j     <= j + 1'b1;
            state <= B_OFS_RD;
          end
        end
        B_REV_RD: begin
          if (i == k) begin
            built      <= 1'b1;
            unique_cnt <= k;
            peak       <= sat_deg(maxo);
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= B_REV_KEY;
          end
        end
        B_REV_KEY: begin
          ereg  <= wa_rd;
          kaddr <= OAW'(wa_rd[19:10]);
          state <= B_REV_WR;
        end
        B_REV_WR: begin
          i     <= i + 1'b1;
          state <= B_REV_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state != S_IDLE);
  assign edge_total        = built ? 13'(unique_cnt) : 13'(loaded);
  assign vertex_total      = 11'(distinct);
  assign largest_vertex_id = top;
  assign max_out_degree    = peak;

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != S_IDLE) && (state == S_IDLE))
    else $error("result without work");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block stayed idle");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= EL_C)
    else $error("edge count past store size");

  a_unique_bound: assert property (@(posedge clk) disable iff (rst)
    built |-> (unique_cnt <= loaded))
    else $error("more kept edges than loaded");

endmodule
